// ----- src/crc8fr_pkg.sv -----
// Package for the CRC-8 frame receiver.
// Holds field widths, register indexes, parser phase codes and the CRC step.
// No dependencies.
package crc8fr_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 6;
  localparam int MAX_PAYLOAD_DEF = 32;

  localparam logic [BYTE_W-1:0] CRC_POLY      = 8'hB2;
  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'h00;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 6'd32;

  // Configuration register indexes
  localparam logic REG_HEADER_BYTE = 1'b0;
  localparam logic REG_MAX_LEN     = 1'b1;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_TYPE    = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CRC     = 5'b10000
  } phase_t;

  // One byte of reflected CRC-8, eight shift steps
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/crc8_frame_receiver_unit.sv -----
// CRC-8 frame receiver, top level.
// Uses crc8fr_pkg; holds the parser, the two-bank payload memory and the
// output drain.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   transaction. The parser hunts for header_byte, takes type and length,
//   then the payload bytes and a trailing CRC-8 (reflected, poly 0xB2, init 0).
//   Output channel (out_valid/out_ready) delivers, for a frame whose CRC
//   matches, one header transaction (is_header = 1, payload_byte = 0) and then
//   one transaction per payload byte; last marks the final one. Bad CRC or an
//   oversized length drops the frame silently.
//   Configuration (cfg_en, cfg_index, cfg_data): index 0 header_byte, index 1
//   max_len; write only while idle.
//   Throughput: one input byte per cycle and, while out_ready is high, one
//   result per cycle. Payload is kept in a two-bank memory, so the next
//   frame fills one bank while the previous one drains from the other; a CRC
//   byte waits (in_ready low) only while an earlier frame is still being read
//   out of the memory. Once the CRC byte is taken, the header result passes
//   the drain issue, the read stage and the output register; payload results
//   follow one per cycle while out_ready holds, limited by the single read port.
//   Reset: parser back to hunting, output empty, header_byte 0, max_len 32.
//   A stalled receiver holds the output register; the drain then pauses and
//   input keeps flowing until the next frame reaches its CRC byte.
module crc8_frame_receiver_unit
  import crc8fr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_en,
  input  logic              cfg_index,
  input  logic [BYTE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_header,
  output logic [BYTE_W-1:0] frame_type,
  output logic [LEN_W-1:0]  frame_len,
  output logic [BYTE_W-1:0] payload_byte,
  output logic              last
);

  localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  // Configuration
  logic [BYTE_W-1:0] header_byte;
  logic [LEN_W-1:0]  max_len;

  // Parser state
  phase_t            phase;
  logic [LEN_W-1:0]  bytes_left;
  logic [BYTE_W-1:0] held_type;
  logic [LEN_W-1:0]  held_len;
  logic [BYTE_W-1:0] running_crc;
  logic [IDX_W-1:0]  wr_ptr;
  logic              wr_bank;

  // Drain sequencer
  logic              drain_active;
  logic              drain_hdr;
  logic              drain_bank;
  logic [IDX_W-1:0]  drain_ptr;
  logic [BYTE_W-1:0] drain_type;
  logic [LEN_W-1:0]  drain_len;

  // Read stage in front of the output register
  logic              s1_valid;
  logic              s1_is_header;
  logic              s1_last;
  logic [BYTE_W-1:0] s1_type;
  logic [LEN_W-1:0]  s1_len;

  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [BYTE_W-1:0] rd_data;

  logic              in_fire;
  logic              len_ok;
  logic              crc_match;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              adv_out;
  logic              issue;
  logic              rd_en;
  logic              drain_ptr_last;
  logic [BYTE_W-1:0] crc_next;

  // Hold the CRC byte back until the other bank has been fully read
  assign in_ready  = !((phase == PH_CRC) && drain_active);
  assign in_fire   = in_valid && in_ready;
  assign len_ok    = (rx_byte <= {{(BYTE_W-LEN_W){1'b0}}, max_len}) &&
                     (rx_byte <= BYTE_W'(MAX_PAYLOAD));
  assign crc_match = (running_crc == rx_byte);
  assign crc_next  = crc8_step(running_crc, rx_byte);
  assign wr_en     = in_fire && (phase == PH_PAYLOAD);
  assign wr_addr   = {wr_bank, wr_ptr};

  assign adv_out        = s1_valid && (!out_valid || out_ready);
  assign issue          = drain_active && (!s1_valid || adv_out);
  assign rd_en          = issue && !drain_hdr;
  assign rd_addr        = {drain_bank, drain_ptr};
  assign drain_ptr_last = ((LEN_W'(drain_ptr) + LEN_W'(1)) == drain_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      max_len     <= MAX_LEN_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_HEADER_BYTE: header_byte <= cfg_data;
        REG_MAX_LEN:     max_len     <= cfg_data[LEN_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      bytes_left   <= '0;
      held_type    <= '0;
      held_len     <= '0;
      running_crc  <= '0;
      wr_ptr       <= '0;
      wr_bank      <= 1'b0;
      drain_active <= 1'b0;
      drain_hdr    <= 1'b0;
      drain_bank   <= 1'b0;
      drain_ptr    <= '0;
    end else begin
      if (in_fire) begin
        case (phase)
          PH_TYPE: begin
            held_type   <= rx_byte;
            running_crc <= crc_next;
            phase       <= PH_LEN;
          end
          PH_LEN: begin
            if (len_ok) begin
              held_len    <= rx_byte[LEN_W-1:0];
              bytes_left  <= rx_byte[LEN_W-1:0];
              running_crc <= crc_next;
              wr_ptr      <= '0;
              phase       <= (rx_byte == '0) ? PH_CRC : PH_PAYLOAD;
            end else begin
              phase <= PH_HUNT;
            end
          end
          PH_PAYLOAD: begin
            running_crc <= crc_next;
            wr_ptr      <= wr_ptr + IDX_W'(1);
            bytes_left  <= bytes_left - LEN_W'(1);
            if (bytes_left == LEN_W'(1)) begin
              phase <= PH_CRC;
            end
          end
          PH_CRC: begin
            // Hand the filled bank to the drain and switch banks
            if (crc_match) begin
              drain_active <= 1'b1;
              drain_hdr    <= 1'b1;
              drain_bank   <= wr_bank;
              drain_ptr    <= '0;
              wr_bank      <= !wr_bank;
            end
            phase <= PH_HUNT;
          end
          default: begin
            phase <= PH_HUNT;
            if (rx_byte == header_byte) begin
              running_crc <= crc8_step('0, rx_byte);
              bytes_left  <= '0;
              phase       <= PH_TYPE;
            end
          end
        endcase
      end
      if (issue) begin
        if (drain_hdr) begin
          drain_hdr <= 1'b0;
          if (drain_len == '0) begin
            drain_active <= 1'b0;
          end
        end else begin
          drain_ptr <= drain_ptr + IDX_W'(1);
          if (drain_ptr_last) begin
            drain_active <= 1'b0;
          end
        end
      end
    end
  end

  // Frame type and length travel with the drain; the parser may move on
  always_ff @(posedge clk) begin
    if (in_fire && (phase == PH_CRC) && crc_match) begin
      drain_type <= held_type;
      drain_len  <= held_len;
    end
  end

  // Payload memory: one write port for the parser, one read port for the drain
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (adv_out) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_is_header <= drain_hdr;
      s1_last      <= drain_hdr ? (drain_len == '0) : drain_ptr_last;
      s1_type      <= drain_type;
      s1_len       <= drain_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      is_header    <= s1_is_header;
      frame_type   <= s1_type;
      frame_len    <= s1_len;
      payload_byte <= s1_is_header ? '0 : rd_data;
      last         <= s1_last;
    end
  end

endmodule

// ----- src/crc8fr_checker.sv -----
// Port-level checker for the CRC-8 frame receiver, with its bind.
// Uses crc8fr_pkg; attaches to crc8_frame_receiver_unit.
module crc8fr_checker
  import crc8fr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              is_header,
  input logic [BYTE_W-1:0] frame_type,
  input logic [LEN_W-1:0]  frame_len,
  input logic [BYTE_W-1:0] payload_byte,
  input logic              last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_header) &&
      $stable(frame_type) && $stable(frame_len) && $stable(payload_byte) &&
      $stable(last))
    else $error("stalled result changed");

  a_hdr_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_header |-> (payload_byte == '0) && (last == (frame_len == '0)))
    else $error("header item payload or last mark wrong");

  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_header |-> frame_len != '0)
    else $error("payload item in an empty frame");

  // A frame drains without gaps once its header has gone
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && !is_header)
    else $error("gap or new header inside a frame");

endmodule

bind crc8_frame_receiver_unit crc8fr_checker u_crc8fr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .is_header    (is_header),
  .frame_type   (frame_type),
  .frame_len    (frame_len),
  .payload_byte (payload_byte),
  .last         (last)
);

// ----- tb/tb_crc8_frame_receiver_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for crc8_frame_receiver_unit: feeds received bytes,
// predicts the frame results in order and checks every output transaction.
// Depends on crc8fr_pkg and the unit itself.
module tb_crc8_frame_receiver_unit;
  import crc8fr_pkg::*;

  localparam int PAY_DEPTH   = MAX_PAYLOAD_DEF;
  localparam int SETTLE_CYC  = 8;
  localparam int HOLD_CYC    = 400;
  localparam int STAGE_BYTES = 60;
  localparam int N_STAGES    = 5;
  localparam int N_DIRECTED  = 20;

  typedef struct packed {
    logic              is_hdr;
    logic [BYTE_W-1:0] ftype;
    logic [LEN_W-1:0]  flen;
    logic [BYTE_W-1:0] pbyte;
    logic              lst;
  } frame_item_t;

  typedef enum logic [1:0] {SRC_RAW, SRC_CRC_GOOD, SRC_CRC_BAD} byte_src_t;

  typedef struct packed {
    byte_src_t         src;
    logic [BYTE_W-1:0] val;
    logic              typed;     // expectation written in the row
    logic              has_item;  // typed row that yields one result
    frame_item_t       item;
  } dir_row_t;

  localparam frame_item_t NO_ITEM = '0;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_en    = 1'b0;
  logic              cfg_index = REG_HEADER_BYTE;
  logic [BYTE_W-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              is_header;
  logic [BYTE_W-1:0] frame_type;
  logic [LEN_W-1:0]  frame_len;
  logic [BYTE_W-1:0] payload_byte;
  logic              last;

  // Predictor state and configuration
  logic [BYTE_W-1:0] hdr_cfg    = HEADER_RESET;
  logic [LEN_W-1:0]  maxlen_cfg = MAX_LEN_RESET;
  phase_t            parse_ph   = PH_HUNT;
  logic [LEN_W-1:0]  left_cnt   = '0;
  logic [BYTE_W-1:0] frm_type   = '0;
  logic [LEN_W-1:0]  frm_len    = '0;
  logic [BYTE_W-1:0] crc_acc    = '0;
  logic [BYTE_W-1:0] pay_mem [PAY_DEPTH];

  frame_item_t due_items[$];
  int          err_cnt  = 0;
  bit          tx_calm  = 1'b0;
  bit          rx_calm  = 1'b0;
  bit          hold_req = 1'b0;
  dir_row_t    dir_table [N_DIRECTED];

  crc8_frame_receiver_unit #(.MAX_PAYLOAD(PAY_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_header(is_header), .frame_type(frame_type), .frame_len(frame_len),
    .payload_byte(payload_byte), .last(last)
  );

  always #5 clk = ~clk;

  // Shift the byte in LSB first against the reflected register
  function automatic logic [BYTE_W-1:0] crc8_reflect_byte(input logic [BYTE_W-1:0] acc,
                                                          input logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] r;
    logic              fb;
    r = acc;
    for (int k = 0; k < BYTE_W; k++) begin
      fb = r[0] ^ d[k];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  // Advance the parser by one byte; queue the frame results on a CRC match
  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b, input bit keep);
    logic [LEN_W-1:0] idx;
    frame_item_t      it;
    case (parse_ph)
      PH_TYPE: begin
        frm_type = b;
        crc_acc  = crc8_reflect_byte(crc_acc, b);
        parse_ph = PH_LEN;
      end
      PH_LEN: begin
        if (b <= maxlen_cfg && b <= PAY_DEPTH) begin
          frm_len  = b[LEN_W-1:0];
          left_cnt = b[LEN_W-1:0];
          crc_acc  = crc8_reflect_byte(crc_acc, b);
          parse_ph = (frm_len == 0) ? PH_CRC : PH_PAYLOAD;
        end else begin
          // drop the frame; this byte is never taken as a header
          parse_ph = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        idx = frm_len - left_cnt;
        if (idx < PAY_DEPTH) pay_mem[idx] = b;
        crc_acc  = crc8_reflect_byte(crc_acc, b);
        left_cnt = left_cnt - 1'b1;
        if (left_cnt == 0) parse_ph = PH_CRC;
      end
      PH_CRC: begin
        if (keep && crc_acc == b) begin
          it.is_hdr = 1'b1;
          it.ftype  = frm_type;
          it.flen   = frm_len;
          it.pbyte  = '0;
          it.lst    = (frm_len == 0);
          due_items.push_back(it);
          for (int i = 0; i < frm_len && i < PAY_DEPTH; i++) begin
            it.is_hdr = 1'b0;
            it.pbyte  = pay_mem[i];
            it.lst    = (i + 1 == frm_len);
            due_items.push_back(it);
          end
        end
        parse_ph = PH_HUNT;
      end
      default: begin
        parse_ph = PH_HUNT;
        if (b == hdr_cfg) begin
          crc_acc  = crc8_reflect_byte('0, b);
          left_cnt = '0;
          parse_ph = PH_TYPE;
        end
      end
    endcase
  endtask

  task automatic drive_byte(input byte_src_t src, input logic [BYTE_W-1:0] val,
                            input bit keep);
    int                gap;
    logic [BYTE_W-1:0] b;
    gap = tx_calm ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    case (src)
      SRC_CRC_GOOD: b = crc_acc;
      // a wrong CRC byte that equals the header where possible
      SRC_CRC_BAD:  b = (crc_acc != hdr_cfg) ? hdr_cfg : ~crc_acc;
      default:      b = val;
    endcase
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    parse_rx_byte(b, keep);
  endtask

  // Hold the input, let every expected result drain, then let the pipe settle
  task automatic quiesce();
    in_valid <= 1'b0;
    while (due_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] h, input logic [LEN_W-1:0] m);
    cfg_en    <= 1'b1;
    cfg_index <= REG_HEADER_BYTE;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_MAX_LEN;
    cfg_data  <= {2'b00, m};
    @(posedge clk);
    cfg_en     <= 1'b0;
    hdr_cfg    = h;
    maxlen_cfg = m;
  endtask

  task automatic send_frame(output int n_sent);
    int pick;
    int len;
    int lo;
    pick   = $urandom_range(0, 99);
    n_sent = 0;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
      drive_byte(SRC_RAW, BYTE_W'($urandom_range(0, 255)), 1'b1);
      n_sent++;
    end
    drive_byte(SRC_RAW, hdr_cfg, 1'b1);
    drive_byte(SRC_RAW, BYTE_W'($urandom_range(0, 255)), 1'b1);
    n_sent += 2;
    if (pick >= 80 && pick < 88) begin
      lo = maxlen_cfg + 1;
      case ($urandom_range(0, 3))
        0:       len = lo;
        1:       len = 255;
        2:       len = (hdr_cfg > maxlen_cfg) ? hdr_cfg : 255;
        default: len = $urandom_range(lo, 255);
      endcase
      drive_byte(SRC_RAW, BYTE_W'(len), 1'b1);
      n_sent++;
      return;
    end
    if ($urandom_range(0, 9) == 0)      len = int'(maxlen_cfg);
    else if ($urandom_range(0, 3) == 0) len = $urandom_range(0, maxlen_cfg);
    else                                len = $urandom_range(0, (maxlen_cfg < 6) ? maxlen_cfg : 6);
    drive_byte(SRC_RAW, BYTE_W'(len), 1'b1);
    repeat (len) drive_byte(SRC_RAW, BYTE_W'($urandom_range(0, 255)), 1'b1);
    n_sent += 1 + len;
    // the rest end early, so the next byte driven is taken as their CRC byte
    if (pick < 80) begin
      drive_byte(SRC_CRC_GOOD, '0, 1'b1);
      n_sent++;
    end else if (pick < 94) begin
      drive_byte(SRC_CRC_BAD, '0, 1'b1);
      n_sent++;
    end
  endtask

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_result(input frame_item_t got);
    frame_item_t want;
    if (due_items.size() == 0) begin
      $display({"%0t ns: result with none expected: ",
                "is_header=%0b type=%02h len=%0d byte=%02h last=%0b"},
               $time, got.is_hdr, got.ftype, got.flen, got.pbyte, got.lst);
      err_cnt++;
      return;
    end
    want = due_items.pop_front();
    cmp_field("is_header", int'(want.is_hdr), int'(got.is_hdr));
    cmp_field("frame_type", int'(want.ftype), int'(got.ftype));
    cmp_field("frame_len", int'(want.flen), int'(got.flen));
    cmp_field("payload_byte", int'(want.pbyte), int'(got.pbyte));
    cmp_field("last", int'(want.lst), int'(got.lst));
  endtask

  initial begin : result_sink
    int          gap;
    frame_item_t got;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // hold off long enough for the unit to fill and stall its input
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      gap = rx_calm ? 0 : draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.is_hdr = is_header;
      got.ftype  = frame_type;
      got.flen   = frame_len;
      got.pbyte  = payload_byte;
      got.lst    = last;
      check_result(got);
    end
  end

  initial begin : byte_source
    int                sent;
    int                stage_sent;
    bit                paused;
    logic [BYTE_W-1:0] h;
    logic [LEN_W-1:0]  m;
    // reset settings: header 0x00, max length 32
    dir_table = '{
      '{SRC_RAW,      8'h55, 1'b1, 1'b0, NO_ITEM},  // not a header while hunting
      '{SRC_RAW,      8'h00, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'hFF, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h00, 1'b1, 1'b0, NO_ITEM},  // zero length
      '{SRC_CRC_GOOD, 8'h00, 1'b1, 1'b1, '{1'b1, 8'hFF, 6'd0, 8'h00, 1'b1}},
      '{SRC_RAW,      8'h00, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'hA5, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h21, 1'b1, 1'b0, NO_ITEM},  // one above the limit
      '{SRC_RAW,      8'h00, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h12, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h03, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h00, 1'b1, 1'b0, NO_ITEM},  // header value as data
      '{SRC_RAW,      8'hFF, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h80, 1'b1, 1'b0, NO_ITEM},
      '{SRC_CRC_GOOD, 8'h00, 1'b0, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h00, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h34, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h01, 1'b1, 1'b0, NO_ITEM},
      '{SRC_RAW,      8'h77, 1'b1, 1'b0, NO_ITEM},
      '{SRC_CRC_BAD,  8'h00, 1'b1, 1'b0, NO_ITEM}
    };
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      drive_byte(dir_table[r].src, dir_table[r].val, !dir_table[r].typed);
      if (dir_table[r].typed && dir_table[r].has_item) due_items.push_back(dir_table[r].item);
    end

    for (int stage = 0; stage < N_STAGES; stage++) begin
      quiesce();
      case (stage)
        0:       begin h = 8'hA5; m = 6'd32; end
        1:       begin h = 8'hFF; m = 6'd0;  end
        2:       begin h = 8'h00; m = 6'd31; end
        3:       begin
          h = BYTE_W'($urandom_range(0, 255));
          m = LEN_W'($urandom_range(1, 32));
        end
        default: begin h = 8'h5A; m = 6'd32; end
      endcase
      set_config(h, m);
      tx_calm = (stage >= 3);
      rx_calm = (stage == 3);
      if (stage == 4) hold_req = 1'b1;
      stage_sent = 0;
      while (stage_sent < STAGE_BYTES) begin
        if (stage == 0 && !paused && stage_sent >= STAGE_BYTES / 2) begin
          paused = 1'b1;
          quiesce();
        end
        send_frame(sent);
        stage_sent += sent;
      end
    end

    quiesce();
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
